[hw/rtl/bia_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types, codes and helpers of the bitmap index allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int FIRST_W     = 15;
   localparam int COUNT_W     = 11;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = 6;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_INDEX = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 8'd1;

   localparam logic [FIRST_W-1:0] FIRST_RESET = 15'd0;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Position of the lowest set bit of a map word.
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/bitmap_index_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_index_allocator
// Next-fit index allocator over a configured range, kept as a used-bit map
// in 64-bit words with a next-free pointer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tuser: kind; tdata: index
//  rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: granted, used
//  csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// A free or a query reads its map word, then clears its bit (free) or reads it
// (query), and then forms its result; a beat that is out of range, finds the map
// full or has an unused kind goes straight to its result. An allocate needs no
// scan when the next free slot lies in the same map word; otherwise the single
// map read port scans one word per cycle. After reset and each register write a
// clearing pass writes one map word per cycle; a waiting result stalls the block.
// ----------------------------------------------------------------------------
module bitmap_index_allocator #(
   parameter int SLOTS = 1024
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [bia_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [bia_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [bia_pkg::INDEX_W-1:0]           req_tdata,  // [15:0] index
   input  wire  [bia_pkg::KIND_W-1:0]            req_tuser,  // [1:0] kind
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [bia_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [15:0] granted_index,
                                                             // [16] is_used
   output logic [bia_pkg::STATUS_W-1:0]          rsp_tuser   // [1:0] status
);

   localparam int WORDS = (SLOTS + bia_pkg::WORD_BITS - 1) / bia_pkg::WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int FW    = AW + bia_pkg::BIT_W;
   localparam int CW    = FW + 1;
   localparam int BW    = bia_pkg::BIT_W;
   localparam int WB    = bia_pkg::WORD_BITS;

   bia_pkg::state_type state_ff, state_in;

   logic [bia_pkg::FIRST_W-1:0]  first_ff, first_in;
   logic [bia_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [FW-1:0]                nf_ff, nf_in;
   logic                         none_ff, none_in;
   logic                         pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [bia_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [FW-1:0]                tgt_ff, tgt_in;
   logic [WB-1:0]                mod_ff, mod_in;
   logic [AW-1:0]                scan_ff, scan_in;
   logic [AW-1:0]                pend_addr_ff, pend_addr_in;
   logic [bia_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [bia_pkg::INDEX_W-1:0]  granted_ff, granted_in;
   logic                         used_ff, used_in;
   logic [bia_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bia_pkg::INDEX_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic                         rsp_used_ff, rsp_used_in;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [WB-1:0]                wr_data;
   logic [AW-1:0]                rd_addr;
   logic [WB-1:0]                rd_data;

   logic [CW-1:0]                n_c;
   logic [CW-1:0]                n_m1;
   logic [AW-1:0]                last_word;
   logic [BW-1:0]                last_bit;
   logic [bia_pkg::INDEX_W:0]    diff;
   logic                         in_range;
   logic [FW-1:0]                req_off;
   logic [FW-1:0]                nf_norm;
   logic [FW-1:0]                req_tgt;
   logic [AW-1:0]                tgt_word;
   logic [BW-1:0]                tgt_bit;
   logic [WB-1:0]                tgt_onehot;
   logic [WB-1:0]                set_word;
   logic [WB-1:0]                upper_free;
   logic [WB-1:0]                scan_free;
   logic [WB-1:0]                held_free;

   function automatic logic [WB-1:0] word_mask(input logic [AW-1:0] w,
                                               input logic [AW-1:0] lw,
                                               input logic [BW-1:0] lb);
      if (w == lw) begin
         return {WB{1'b1}} >> (~lb);
      end
      return {WB{1'b1}};
   endfunction

   function automatic logic [AW-1:0] next_word(input logic [AW-1:0] w,
                                               input logic [AW-1:0] lw);
      if (w == lw) begin
         return '0;
      end
      return w + AW'(1);
   endfunction

   bia_map_ram #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Effective slot count: zero counts as one, large counts saturate.
   always_comb begin
      if (count_ff == '0) begin
         n_c = CW'(1);
      end else if (32'(count_ff) > 32'(SLOTS)) begin
         n_c = CW'(SLOTS);
      end else begin
         n_c = CW'(count_ff);
      end
   end

   assign n_m1      = n_c - CW'(1);
   assign last_word = n_m1[FW-1:BW];
   assign last_bit  = n_m1[BW-1:0];

   assign diff     = {1'b0, req_tdata} - {2'b00, first_ff};
   assign in_range = !diff[bia_pkg::INDEX_W] &&
                     (32'(diff[bia_pkg::INDEX_W-1:0]) < 32'(n_c));
   assign req_off  = FW'(diff[bia_pkg::INDEX_W-1:0]);
   assign nf_norm  = (32'(nf_ff) >= 32'(n_c)) ? '0 : nf_ff;
   assign req_tgt  = (req_tuser == bia_pkg::KIND_ALLOC) ? nf_norm : req_off;

   assign tgt_word   = tgt_ff[FW-1:BW];
   assign tgt_bit    = tgt_ff[BW-1:0];
   assign tgt_onehot = WB'(1) << tgt_bit;
   assign set_word   = rd_data | tgt_onehot;
   // Free slots above the one just granted, within the same word.
   assign upper_free = ~set_word & (({WB{1'b1}} << tgt_bit) << 1) &
                       word_mask(tgt_word, last_word, last_bit);
   assign scan_free  = ~rd_data & word_mask(pend_addr_ff, last_word, last_bit);
   assign held_free  = ~mod_ff & word_mask(tgt_word, last_word, last_bit);

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == bia_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_used_ff, rsp_granted_ff};

   always_comb begin
      state_in       = state_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      clr_in         = clr_ff;
      nf_in          = nf_ff;
      none_in        = none_ff;
      pend_in        = pend_ff;
      kind_in        = kind_ff;
      tgt_in         = tgt_ff;
      mod_in         = mod_ff;
      scan_in        = scan_ff;
      pend_addr_in   = pend_addr_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      used_in        = used_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      wr_en          = 1'b0;
      wr_addr        = tgt_word;
      wr_data        = '0;
      rd_addr        = scan_ff;

      unique case (state_ff)
         bia_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = bia_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         bia_pkg::ST_IDLE: begin
            rd_addr = req_tgt[FW-1:BW];
            if (req_tvalid) begin
               kind_in    = req_tuser;
               tgt_in     = req_tgt;
               nf_in      = nf_norm;
               status_in  = bia_pkg::STATUS_OK;
               granted_in = '0;
               used_in    = 1'b0;
               state_in   = bia_pkg::ST_RESP;
               case (req_tuser)
                  bia_pkg::KIND_ALLOC: begin
                     if (none_ff) begin
                        status_in = bia_pkg::STATUS_FULL;
                     end else begin
                        granted_in = bia_pkg::INDEX_W'(32'(first_ff) + 32'(nf_norm));
                        state_in   = bia_pkg::ST_MODIFY;
                     end
                  end
                  bia_pkg::KIND_FREE, bia_pkg::KIND_QUERY: begin
                     if (in_range) begin
                        state_in = bia_pkg::ST_MODIFY;
                     end else begin
                        status_in = bia_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bia_pkg::ST_MODIFY: begin
            state_in = bia_pkg::ST_RESP;
            case (kind_ff)
               bia_pkg::KIND_QUERY: begin
                  used_in = rd_data[tgt_bit];
               end
               bia_pkg::KIND_FREE: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~tgt_onehot;
                  if ((tgt_ff < nf_ff) || none_ff) begin
                     nf_in   = tgt_ff;
                     none_in = 1'b0;
                  end
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_data = set_word;
                  mod_in  = set_word;
                  if (|upper_free) begin
                     nf_in = {tgt_word, bia_pkg::lowest_set(upper_free)};
                  end else begin
                     pend_in  = 1'b0;
                     scan_in  = next_word(tgt_word, last_word);
                     state_in = bia_pkg::ST_SCAN;
                  end
               end
            endcase
         end
         bia_pkg::ST_SCAN: begin
            // Each cycle checks the word read last cycle and reads the next one.
            // The granted slot's own word is checked last, from the held copy.
            if (pend_ff && (|scan_free)) begin
               nf_in    = {pend_addr_ff, bia_pkg::lowest_set(scan_free)};
               state_in = bia_pkg::ST_RESP;
            end else if (scan_ff == tgt_word) begin
               if (|held_free) begin
                  nf_in = {tgt_word, bia_pkg::lowest_set(held_free)};
               end else begin
                  none_in = 1'b1;
               end
               state_in = bia_pkg::ST_RESP;
            end else begin
               pend_in      = 1'b1;
               pend_addr_in = scan_ff;
               scan_in      = next_word(scan_ff, last_word);
            end
         end
         bia_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = granted_ff;
               rsp_used_in    = used_ff;
               state_in       = bia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bia_pkg::ST_CLEAR;
         end
      endcase

      // A register write starts a new, empty range.
      if (csr_valid && ((csr_index == bia_pkg::CSR_FIRST_INDEX) ||
                        (csr_index == bia_pkg::CSR_SLOT_COUNT))) begin
         if (csr_index == bia_pkg::CSR_FIRST_INDEX) begin
            first_in = csr_wdata[bia_pkg::FIRST_W-1:0];
         end else begin
            count_in = csr_wdata[bia_pkg::COUNT_W-1:0];
         end
         clr_in   = '0;
         nf_in    = '0;
         none_in  = 1'b0;
         state_in = bia_pkg::ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bia_pkg::ST_CLEAR;
         first_ff     <= bia_pkg::FIRST_RESET;
         count_ff     <= bia_pkg::COUNT_RESET;
         clr_ff       <= '0;
         nf_ff        <= '0;
         none_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         nf_ff        <= nf_in;
         none_ff      <= none_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      tgt_ff         <= tgt_in;
      mod_ff         <= mod_in;
      scan_ff        <= scan_in;
      pend_addr_ff   <= pend_addr_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      used_ff        <= used_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
   end

endmodule
`default_nettype wire

[hw/rtl/bia_map_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bia_map_ram
// Used-bit map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bia_map_ram #(
   parameter int WORDS = 16,
   parameter int AW    = 4
) (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire  [AW-1:0]                    wr_addr,
   input  wire  [bia_pkg::WORD_BITS-1:0]    wr_data,
   input  wire  [AW-1:0]                    rd_addr,
   output logic [bia_pkg::WORD_BITS-1:0]    rd_data
);

   logic [bia_pkg::WORD_BITS-1:0] mem [WORDS];
   logic [bia_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
